[sv/srbs_pkg.sv]
package srbs_pkg;

    // Default sizes of the canvas memory and of the brush.
    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned MAX_HEIGHT_DEF = 1024;
    localparam int unsigned MAX_RADIUS_DEF = 31;

    // Field widths fixed by the interface.
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned RADIUS_W = 5;
    localparam int unsigned CANVAS_W = 11;
    localparam int unsigned COUNT_W  = 12;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned FRAC_IDX_W = 4;
    localparam int unsigned SQ_W     = 2 * FRAC_W;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Canvas size after reset.
    localparam logic [CANVAS_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CANVAS_W-1:0] HEIGHT_RST = 11'd480;

    // Operation codes.
    localparam logic OP_STAMP = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_PIX,
        ST_SQ_A,
        ST_SQ_B,
        ST_BLEND,
        ST_ADV,
        ST_OUT
    } state_t;

    // Blend one 8-bit channel from the brush value toward the old value.
    function automatic logic [7:0] blend_ch(input logic [7:0] from_c,
                                            input logic [7:0] to_c,
                                            input logic [FRAC_W-1:0] v);
        logic [7:0]  diff;
        logic [23:0] prod;
        logic [7:0]  mag;
        if (to_c >= from_c) begin
            diff = to_c - from_c;
        end else begin
            diff = from_c - to_c;
        end
        prod = {16'd0, diff} * {8'd0, v};
        mag  = prod[23:16];
        if (to_c >= from_c) begin
            return from_c + mag;
        end else begin
            return from_c - mag;
        end
    endfunction

endpackage

[sv/soft_round_brush_stamp.sv]
// Channel | Direction | Handshake        | Beat contents
// s_      | in        | s_valid/s_ready  | opcode, center_x, center_y, brush_color, brush_radius
// m_      | out       | m_valid/m_ready  | pixel_value, pixel_valid, pixels_written
// cfg_    | in        | cfg_we           | cfg_index, cfg_wdata (canvas width, height)
//
// After reset the canvas memory is cleared one entry per cycle, all MAX_WIDTH*MAX_HEIGHT
// entries; no beat is accepted during that pass. A read result is offered after ST_RD_WAIT
// copies the registered memory word out, or in the cycle after the beat for an address
// outside the canvas. A stamp of radius r visits 4*r*r offsets in ST_PIX and ST_ADV; for
// each pixel it writes, one shared multiplier finds the fraction one bit at a time in
// ST_SQ_A and ST_SQ_B, and ST_BLEND then writes the blended color.
// A result waits in the output register until taken; the next beat is taken after.
module soft_round_brush_stamp #(
    parameter int unsigned MAX_WIDTH  = srbs_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = srbs_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned MAX_RADIUS = srbs_pkg::MAX_RADIUS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [srbs_pkg::CANVAS_W-1:0]       cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic signed [srbs_pkg::COORD_W-1:0] s_center_x,
    input  logic signed [srbs_pkg::COORD_W-1:0] s_center_y,
    input  logic [srbs_pkg::COLOR_W-1:0]        s_brush_color,
    input  logic [srbs_pkg::RADIUS_W-1:0]       s_brush_radius,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [srbs_pkg::COLOR_W-1:0]        m_pixel_value,
    output logic                                m_pixel_valid,
    output logic [srbs_pkg::COUNT_W-1:0]        m_pixels_written
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned RUW   = $clog2(MAX_RADIUS + 1);
    localparam int unsigned RW    = RUW + 1;
    localparam int unsigned R2W   = 2 * RUW;
    localparam int unsigned D2W   = 2 * RW;
    localparam int unsigned CW    = srbs_pkg::SQ_W + D2W;
    localparam int unsigned PW    = srbs_pkg::COORD_W + 2;

    srbs_pkg::state_t state_reg, state_next;

    logic [srbs_pkg::CANVAS_W-1:0] cw_reg, ch_reg;
    logic signed [srbs_pkg::COORD_W-1:0] cx_reg, cy_reg;
    logic [srbs_pkg::COLOR_W-1:0] color_reg;
    logic [RUW-1:0] r_reg;
    logic [R2W-1:0] r2_reg;
    logic signed [RW-1:0] dx_reg, dy_reg;
    logic [D2W-1:0] d2_reg;
    logic [AW-1:0] addr_reg, clr_reg;
    logic [srbs_pkg::FRAC_W-1:0] v_reg;
    logic [srbs_pkg::SQ_W-1:0] sq_reg, trial_reg;
    logic [srbs_pkg::FRAC_IDX_W-1:0] bit_reg;
    logic [srbs_pkg::COUNT_W-1:0] count_reg;
    logic [srbs_pkg::COLOR_W-1:0] out_value_reg;
    logic out_valid_reg;
    logic [srbs_pkg::COUNT_W-1:0] out_count_reg;

    logic [srbs_pkg::COLOR_W-1:0] mem [DEPTH];
    logic [srbs_pkg::COLOR_W-1:0] rdata_reg;

    // Canvas limits saturated to the memory size.
    logic [PW-1:0] effw, effh;
    always_comb begin
        effw = ({{(PW-srbs_pkg::CANVAS_W){1'b0}}, cw_reg} > PW'(MAX_WIDTH)) ?
               PW'(MAX_WIDTH) : {{(PW-srbs_pkg::CANVAS_W){1'b0}}, cw_reg};
        effh = ({{(PW-srbs_pkg::CANVAS_W){1'b0}}, ch_reg} > PW'(MAX_HEIGHT)) ?
               PW'(MAX_HEIGHT) : {{(PW-srbs_pkg::CANVAS_W){1'b0}}, ch_reg};
    end

    // Input beat: read address check and saturated radius.
    logic signed [PW-1:0] in_x, in_y;
    logic in_inside;
    logic [AW-1:0] in_addr;
    logic [RUW-1:0] in_r;
    always_comb begin
        in_x = PW'(s_center_x);
        in_y = PW'(s_center_y);
        in_inside = (in_x >= 0) && (in_y >= 0) &&
                    ($unsigned(in_x) < effw) && ($unsigned(in_y) < effh);
        in_addr = AW'($unsigned(in_y) * PW'(MAX_WIDTH) + $unsigned(in_x));
        if ({{(RW+8-srbs_pkg::RADIUS_W){1'b0}}, s_brush_radius} > (RW+8)'(MAX_RADIUS)) begin
            in_r = RUW'(MAX_RADIUS);
        end else begin
            in_r = RUW'(s_brush_radius);
        end
    end

    // Current offset: distance, position and inclusion.
    logic [RW-1:0] adx, ady;
    logic [D2W-1:0] d2;
    logic signed [PW-1:0] px, py;
    logic pix_ok;
    logic [AW-1:0] pix_addr;
    always_comb begin
        adx = dx_reg[RW-1] ? RW'(-dx_reg) : RW'(dx_reg);
        ady = dy_reg[RW-1] ? RW'(-dy_reg) : RW'(dy_reg);
        d2 = D2W'(adx) * D2W'(adx) + D2W'(ady) * D2W'(ady);
        px = PW'(cx_reg) + PW'(dx_reg);
        py = PW'(cy_reg) + PW'(dy_reg);
        pix_ok = (d2 < D2W'(r2_reg)) && (px >= 0) && (py >= 0) &&
                 ($unsigned(px) < effw) && ($unsigned(py) < effh);
        pix_addr = AW'($unsigned(py) * PW'(MAX_WIDTH) + $unsigned(px));
    end

    // Shared multiplier: trial square times radius squared against d2 << 32.
    logic [CW-1:0] prod, target;
    logic fits;
    always_comb begin
        prod = CW'(trial_reg) * CW'(r2_reg);
        target = {d2_reg, {srbs_pkg::SQ_W{1'b0}}};
        fits = (prod <= target);
    end

    // Next trial square: (v + 2^b)^2 = v^2 + v*2^(b+1) + 2^(2b).
    logic [srbs_pkg::SQ_W-1:0] trial_next;
    always_comb begin
        trial_next = sq_reg + (srbs_pkg::SQ_W'(v_reg) << (bit_reg + 1'b1)) +
                     (srbs_pkg::SQ_W'(1) << {bit_reg, 1'b0});
    end

    // Blended color of the current pixel.
    logic [srbs_pkg::COLOR_W-1:0] blended;
    always_comb begin
        blended = {srbs_pkg::blend_ch(color_reg[23:16], rdata_reg[23:16], v_reg),
                   srbs_pkg::blend_ch(color_reg[15:8],  rdata_reg[15:8],  v_reg),
                   srbs_pkg::blend_ch(color_reg[7:0],   rdata_reg[7:0],   v_reg)};
    end

    logic last_dx, last_dy;
    always_comb begin
        last_dx = (dx_reg + RW'(1)) == $signed({1'b0, r_reg});
        last_dy = (dy_reg + RW'(1)) == $signed({1'b0, r_reg});
    end

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srbs_pkg::ST_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = srbs_pkg::ST_IDLE;
                end
            end
            srbs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == srbs_pkg::OP_READ) begin
                        state_next = in_inside ? srbs_pkg::ST_RD_WAIT : srbs_pkg::ST_OUT;
                    end else begin
                        state_next = (in_r == '0) ? srbs_pkg::ST_OUT : srbs_pkg::ST_PIX;
                    end
                end
            end
            srbs_pkg::ST_RD_WAIT: state_next = srbs_pkg::ST_OUT;
            srbs_pkg::ST_PIX:     state_next = pix_ok ? srbs_pkg::ST_SQ_A : srbs_pkg::ST_ADV;
            srbs_pkg::ST_SQ_A:    state_next = srbs_pkg::ST_SQ_B;
            srbs_pkg::ST_SQ_B: begin
                state_next = (bit_reg == '0) ? srbs_pkg::ST_BLEND : srbs_pkg::ST_SQ_A;
            end
            srbs_pkg::ST_BLEND:   state_next = srbs_pkg::ST_ADV;
            srbs_pkg::ST_ADV: begin
                if (last_dx && last_dy) begin
                    state_next = srbs_pkg::ST_OUT;
                end else begin
                    state_next = srbs_pkg::ST_PIX;
                end
            end
            srbs_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = srbs_pkg::ST_IDLE;
                end
            end
            default: state_next = srbs_pkg::ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srbs_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= srbs_pkg::WIDTH_RST;
            ch_reg <= srbs_pkg::HEIGHT_RST;
        end else if (cfg_we) begin
            if (cfg_index == srbs_pkg::REG_WIDTH) begin
                cw_reg <= cfg_wdata;
            end else begin
                ch_reg <= cfg_wdata;
            end
        end
    end

    // Clearing pass address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (state_reg == srbs_pkg::ST_CLEAR) begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // Canvas memory with registered read.
    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [srbs_pkg::COLOR_W-1:0] mem_wdata;
    always_comb begin
        mem_we    = (state_reg == srbs_pkg::ST_CLEAR) || (state_reg == srbs_pkg::ST_BLEND);
        mem_waddr = (state_reg == srbs_pkg::ST_CLEAR) ? clr_reg : addr_reg;
        mem_wdata = (state_reg == srbs_pkg::ST_CLEAR) ? '0 : blended;
        mem_re    = ((state_reg == srbs_pkg::ST_IDLE) && s_valid) ||
                    ((state_reg == srbs_pkg::ST_PIX) && pix_ok);
        mem_raddr = (state_reg == srbs_pkg::ST_IDLE) ? in_addr : pix_addr;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            srbs_pkg::ST_IDLE: begin
                cx_reg    <= s_center_x;
                cy_reg    <= s_center_y;
                color_reg <= s_brush_color;
                r_reg     <= in_r;
                r2_reg    <= R2W'(in_r) * R2W'(in_r);
                dx_reg    <= -$signed({1'b0, in_r});
                dy_reg    <= -$signed({1'b0, in_r});
                count_reg <= '0;
                out_value_reg <= '0;
                out_valid_reg <= 1'b0;
                out_count_reg <= '0;
            end
            srbs_pkg::ST_RD_WAIT: begin
                out_value_reg <= rdata_reg;
                out_valid_reg <= 1'b1;
            end
            srbs_pkg::ST_PIX: begin
                d2_reg   <= d2;
                addr_reg <= pix_addr;
                v_reg    <= '0;
                sq_reg   <= '0;
                bit_reg  <= srbs_pkg::FRAC_IDX_W'(srbs_pkg::FRAC_W - 1);
            end
            srbs_pkg::ST_SQ_A: begin
                trial_reg <= trial_next;
            end
            srbs_pkg::ST_SQ_B: begin
                if (fits) begin
                    v_reg  <= v_reg | (srbs_pkg::FRAC_W'(1) << bit_reg);
                    sq_reg <= trial_reg;
                end
                bit_reg <= bit_reg - 1'b1;
            end
            srbs_pkg::ST_BLEND: begin
                count_reg <= count_reg + 1'b1;
            end
            srbs_pkg::ST_ADV: begin
                if (last_dx) begin
                    dx_reg <= -$signed({1'b0, r_reg});
                    dy_reg <= dy_reg + RW'(1);
                end else begin
                    dx_reg <= dx_reg + RW'(1);
                end
                if (last_dx && last_dy) begin
                    out_count_reg <= count_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready          = (state_reg == srbs_pkg::ST_IDLE);
    assign m_valid          = (state_reg == srbs_pkg::ST_OUT);
    assign m_pixel_value    = out_value_reg;
    assign m_pixel_valid    = out_valid_reg;
    assign m_pixels_written = out_count_reg;

endmodule
